[hdl/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, constants and a calendar function for the epoch converter
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

  // rounded-up reciprocals, quotient is the product shifted right
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675 on seconds >> 7
  localparam logic [17:0] HOUR_RECIP = 18'd149131;    // 2^29 / 3600
  localparam logic [11:0] MIN_RECIP  = 12'd2185;      // 2^17 / 60
  localparam logic [16:0] WEEK_RECIP = 17'd74899;     // 2^19 / 7

  localparam logic [15:0] EPOCH_WDAY_OFS = 16'd3;
  localparam logic signed [7:0] BASE_YEAR_OFS = -8'sd30;
  localparam logic [6:0] BASE_MOD100 = 7'd70;
  localparam logic [8:0] BASE_MOD400 = 9'd370;
  localparam logic [6:0] LAST_MOD100 = 7'd99;
  localparam logic [8:0] LAST_MOD400 = 9'd399;
  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;
  localparam logic [3:0] FIRST_MONTH = 4'd1;
  localparam logic [3:0] LAST_MONTH  = 4'd12;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD_DAY,
    CMD_DAY_QUO,
    CMD_DAY_REM,
    CMD_HOUR_QUO,
    CMD_HOUR_REM,
    CMD_MIN_QUO,
    CMD_MIN_REM,
    CMD_WEEK_QUO,
    CMD_WEEK_REM,
    CMD_YEAR_STEP,
    CMD_MONTH_STEP,
    CMD_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    logic year_ge;
    logic month_ge;
  } status_t;

  function automatic logic [4:0] month_len_f(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/esc_ctrl.sv]
// ----------------------------------------------------------------------------
// esc_ctrl
// sequencer for the converter: divisions, year walk, month walk, output
// ----------------------------------------------------------------------------
module esc_ctrl
  import esc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DAY_QUO  = 12'b0000_0000_0010,
    S_DAY_REM  = 12'b0000_0000_0100,
    S_HOUR_QUO = 12'b0000_0000_1000,
    S_HOUR_REM = 12'b0000_0001_0000,
    S_MIN_QUO  = 12'b0000_0010_0000,
    S_MIN_REM  = 12'b0000_0100_0000,
    S_WEEK_QUO = 12'b0000_1000_0000,
    S_WEEK_REM = 12'b0001_0000_0000,
    S_YEAR     = 12'b0010_0000_0000,
    S_MONTH    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD_DAY;
          state_d = S_DAY_QUO;
        end
      end
      S_DAY_QUO: begin
        cmd_o   = CMD_DAY_QUO;
        state_d = S_DAY_REM;
      end
      S_DAY_REM: begin
        cmd_o   = CMD_DAY_REM;
        state_d = S_HOUR_QUO;
      end
      S_HOUR_QUO: begin
        cmd_o   = CMD_HOUR_QUO;
        state_d = S_HOUR_REM;
      end
      S_HOUR_REM: begin
        cmd_o   = CMD_HOUR_REM;
        state_d = S_MIN_QUO;
      end
      S_MIN_QUO: begin
        cmd_o   = CMD_MIN_QUO;
        state_d = S_MIN_REM;
      end
      S_MIN_REM: begin
        cmd_o   = CMD_MIN_REM;
        state_d = S_WEEK_QUO;
      end
      S_WEEK_QUO: begin
        cmd_o   = CMD_WEEK_QUO;
        state_d = S_WEEK_REM;
      end
      S_WEEK_REM: begin
        cmd_o   = CMD_WEEK_REM;
        state_d = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_ge) begin
          cmd_o = CMD_YEAR_STEP;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (status_i.month_ge) begin
          cmd_o = CMD_MONTH_STEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o   = CMD_OUT_LOAD;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || (cmd_o == CMD_OUT_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/esc_dpath.sv]
// ----------------------------------------------------------------------------
// esc_dpath
// reciprocal-multiply dividers, year and month counters and the output register
// ----------------------------------------------------------------------------
module esc_dpath
  import esc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_e              cmd_i,
  output status_t           status_o,
  input  logic [31:0]       epoch_seconds_i,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o,
  output logic signed [7:0] year_from_2000_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o,
  output logic [2:0]        weekday_o
);

  logic [31:0]       secs_q, secs_d;
  logic [15:0]       days_q, days_d;
  logic [15:0]       tdays_q, tdays_d;
  logic [16:0]       sod_q, sod_d;
  logic [4:0]        hour_q, hour_d;
  logic [11:0]       mrem_q, mrem_d;
  logic [5:0]        min_q, min_d;
  logic [5:0]        sec_q, sec_d;
  logic [2:0]        wquo_q, wquo_d;
  logic [2:0]        wday_q, wday_d;
  logic signed [7:0] year_q, year_d;
  logic [6:0]        ymod100_q, ymod100_d;
  logic [8:0]        ymod400_q, ymod400_d;
  logic [3:0]        month_q, month_d;

  logic [50:0] day_prod;
  logic [16:0] day_back;
  logic [33:0] hour_prod;
  logic [11:0] hour_back;
  logic [22:0] min_prod;
  logic [5:0]  min_back;
  logic [15:0] week_x;
  logic [31:0] week_prod;
  logic [2:0]  week_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // quotients by reciprocal multiplication, remainders modulo their width
  assign day_prod  = {26'd0, secs_q[31:7]} * {25'd0, DAY_RECIP};
  assign day_back  = {1'b0, days_q} * SECS_PER_DAY;
  assign hour_prod = {17'd0, sod_q} * {16'd0, HOUR_RECIP};
  assign hour_back = {7'd0, hour_q} * SECS_PER_HOUR;
  assign min_prod  = {11'd0, mrem_q} * {11'd0, MIN_RECIP};
  assign min_back  = min_q * SECS_PER_MIN;
  assign week_x    = tdays_q + EPOCH_WDAY_OFS;
  assign week_prod = {16'd0, week_x} * {15'd0, WEEK_RECIP};
  assign week_back = wquo_q * DAYS_PER_WEEK;

  assign leap = ((year_q[1:0] == 2'd0) && (ymod100_q != 7'd0)) || (ymod400_q == 9'd0);
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_len_f(month_q, leap);

  assign status_o.year_ge  = (days_q >= {7'd0, ylen});
  assign status_o.month_ge = (month_q != LAST_MONTH) && (days_q >= {11'd0, mlen});

  always_comb begin
    secs_d    = secs_q;
    days_d    = days_q;
    tdays_d   = tdays_q;
    sod_d     = sod_q;
    hour_d    = hour_q;
    mrem_d    = mrem_q;
    min_d     = min_q;
    sec_d     = sec_q;
    wquo_d    = wquo_q;
    wday_d    = wday_q;
    year_d    = year_q;
    ymod100_d = ymod100_q;
    ymod400_d = ymod400_q;
    month_d   = month_q;
    case (cmd_i)
      CMD_LOAD_DAY: begin
        secs_d    = epoch_seconds_i;
        year_d    = BASE_YEAR_OFS;
        ymod100_d = BASE_MOD100;
        ymod400_d = BASE_MOD400;
        month_d   = FIRST_MONTH;
      end
      CMD_DAY_QUO: begin
        days_d  = day_prod[50:35];
        tdays_d = day_prod[50:35];
      end
      CMD_DAY_REM: begin
        sod_d = secs_q[16:0] - day_back;
      end
      CMD_HOUR_QUO: begin
        hour_d = hour_prod[33:29];
      end
      CMD_HOUR_REM: begin
        mrem_d = sod_q[11:0] - hour_back;
      end
      CMD_MIN_QUO: begin
        min_d = min_prod[22:17];
      end
      CMD_MIN_REM: begin
        sec_d = mrem_q[5:0] - min_back;
      end
      CMD_WEEK_QUO: begin
        wquo_d = week_prod[21:19];
      end
      CMD_WEEK_REM: begin
        wday_d = week_x[2:0] - week_back + 3'd1;
      end
      CMD_YEAR_STEP: begin
        days_d    = days_q - {7'd0, ylen};
        year_d    = year_q + 8'sd1;
        ymod100_d = (ymod100_q == LAST_MOD100) ? 7'd0 : ymod100_q + 7'd1;
        ymod400_d = (ymod400_q == LAST_MOD400) ? 9'd0 : ymod400_q + 9'd1;
      end
      CMD_MONTH_STEP: begin
        days_d  = days_q - {11'd0, mlen};
        month_d = month_q + 4'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secs_q    <= '0;
      days_q    <= '0;
      tdays_q   <= '0;
      sod_q     <= '0;
      hour_q    <= '0;
      mrem_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      wquo_q    <= '0;
      wday_q    <= '0;
      year_q    <= '0;
      ymod100_q <= '0;
      ymod400_q <= '0;
      month_q   <= '0;
    end else begin
      secs_q    <= secs_d;
      days_q    <= days_d;
      tdays_q   <= tdays_d;
      sod_q     <= sod_d;
      hour_q    <= hour_d;
      mrem_q    <= mrem_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      wquo_q    <= wquo_d;
      wday_q    <= wday_d;
      year_q    <= year_d;
      ymod100_q <= ymod100_d;
      ymod400_q <= ymod400_d;
      month_q   <= month_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_OUT_LOAD) begin
      hour_o           <= hour_q;
      minute_o         <= min_q;
      second_o         <= sec_q;
      year_from_2000_o <= year_q;
      month_o          <= month_q;
      day_of_month_o   <= days_q[4:0] + 5'd1;
      weekday_o        <= wday_q;
    end
  end

endmodule

[hdl/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts a 32-bit seconds-since-1970 count into time of day, date, weekday
//
// input channel: in_valid_i / in_stall_o with epoch_seconds_i; a transaction
//   is taken when valid is high and stall is low, only while no conversion
//   is in progress
// output channel: out_valid_o / out_stall_i with the calendar fields; the
//   result sits in an output register and holds while out_stall_i is high
// after an input transaction the sequencer runs four reciprocal-multiply
//   divisions (days, hours, minutes, weekday), each a quotient step and
//   then a remainder step, then one step per elapsed year (up to 136) and
//   a final year check, one step per elapsed month (up to 11) and a final
//   month check, and a step to load the output register; elapsed years
//   and months together are at most 146
// the next input is taken while the previous result still waits in the
//   output register
// a stalled receiver holds a finished conversion in its last step until the
//   output register frees up
// reset: asynchronous, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       epoch_seconds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o,
  output logic signed [7:0] year_from_2000_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o,
  output logic [2:0]        weekday_o
);

  cmd_e    cmd;
  status_t status;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  esc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .epoch_seconds_i  (epoch_seconds_i),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .second_o         (second_o),
    .year_from_2000_o (year_from_2000_o),
    .month_o          (month_o),
    .day_of_month_o   (day_of_month_o),
    .weekday_o        (weekday_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transaction");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o != 4'd0) && (month_o <= LAST_MONTH))
    else $error("month out of range");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weekday_o != 3'd0) && (day_of_month_o != 5'd0))
    else $error("weekday or day of month zero");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("time of day out of range");

endmodule

[tb/sv/epoch_seconds_to_calendar_tb.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// checks the epoch converter against its own calendar predictor: directed
// corner dates first, then random timestamps with idle bursts on both sides,
// a long receiver hold-off with the sender still offering, drained pauses and
// a final stretch without idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned TAIL_CYCLES  = 250;

  typedef struct {
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic signed [7:0] year_from_2000;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [2:0]        weekday;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t   pending_dates[$];
    int unsigned errors = 0;
    int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function calendar_t convert_epoch(input logic [31:0] secs);
      calendar_t   c;
      int unsigned days, sod, total, year, month, span;
      days  = secs / 32'd86400;
      sod   = secs % 32'd86400;
      total = days;
      year  = 1970;
      month = 1;
      forever begin
        span = leap_year(year) ? 366 : 365;
        if (days < span) break;
        days -= span;
        year++;
      end
      while (month < 12) begin
        span = month_days[month - 1];
        if (month == 2 && leap_year(year)) span = 29;
        if (days < span) break;
        days -= span;
        month++;
      end
      c.hour           = 5'(sod / 3600);
      c.minute         = 6'((sod % 3600) / 60);
      c.second         = 6'(sod % 60);
      c.year_from_2000 = 8'(year - 2000);
      c.month          = 4'(month);
      c.day_of_month   = 5'(days + 1);
      c.weekday        = 3'((total + 3) % 7 + 1);
      return c;
    endfunction

    function void note_input(input logic [31:0] secs);
      pending_dates.push_back(convert_epoch(secs));
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, got.year_from_2000, got.month, got.day_of_month,
                 got.hour, got.minute, got.second);
        return;
      end
      want = pending_dates.pop_front();
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("year_from_2000", want.year_from_2000, got.year_from_2000);
      compare_field("month", want.month, got.month);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("weekday", want.weekday, got.weekday);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       epoch_seconds_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [4:0]        hour_o;
  logic [5:0]        minute_o;
  logic [5:0]        second_o;
  logic signed [7:0] year_from_2000_o;
  logic [3:0]        month_o;
  logic [4:0]        day_of_month_o;
  logic [2:0]        weekday_o;

  calendar_scoreboard sb = new();
  bit                 steady = 1'b0;
  bit                 sender_gaps = 1'b1;
  int unsigned        hold_off_count = 0;
  int unsigned        cycle_count = 0;

  epoch_seconds_to_calendar dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .epoch_seconds_i  (epoch_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .second_o         (second_o),
    .year_from_2000_o (year_from_2000_o),
    .month_o          (month_o),
    .day_of_month_o   (day_of_month_o),
    .weekday_o        (weekday_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: checks each transaction, then picks the next stall value
  initial begin
    calendar_t   got;
    int unsigned hold_left, stall_left, run_left, holds_seen;
    hold_left  = 0;
    stall_left = 0;
    run_left   = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.hour           = hour_o;
        got.minute         = minute_o;
        got.second         = second_o;
        got.year_from_2000 = year_from_2000_o;
        got.month          = month_o;
        got.day_of_month   = day_of_month_o;
        got.weekday        = weekday_o;
        sb.check_result(got);
      end
      if (hold_off_count != holds_seen) begin
        holds_seen = hold_off_count;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (run_left != 0) begin
        run_left--;
        out_stall_i <= 1'b0;
      end else begin
        stall_left = $urandom_range(1, 12);
        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(0, 30);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_epoch(input logic [31:0] secs);
    int unsigned gap;
    if (!steady && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(secs);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_dates.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_epoch();
    int unsigned pick, day;
    pick = $urandom_range(0, 9);
    day  = $urandom_range(0, 49709);
    case (pick)
      6:       return day * 86400;
      7:       return day * 86400 + 86399;
      8:       return $urandom_range(0, 200000000);
      9:       return $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_epoch(random_epoch());
  endtask

  initial begin
    logic [31:0] corner_dates[$];
    corner_dates = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                     32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799,
                     32'd1709164800, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4107542399,
                     32'd4107542400, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_dates[i]) send_epoch(corner_dates[i]);
    send_random(580);

    // hold the receiver off while the sender keeps pushing
    sender_gaps = 1'b0;
    hold_off_count++;
    send_random(24);
    sender_gaps = 1'b1;
    wait_drained();

    send_random(575);
    wait_drained();

    steady = 1'b1;
    send_random(650);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[epoch_seconds_to_calendar.f]
hdl/esc_pkg.sv
hdl/esc_ctrl.sv
hdl/esc_dpath.sv
hdl/epoch_seconds_to_calendar.sv
tb/sv/epoch_seconds_to_calendar_tb.sv
